// ===== rtl/multi_stack_shared_array_unit_assert.svh =====
// Assertion macros for the multi-stack unit.
`ifndef MULTI_STACK_SHARED_ARRAY_UNIT_ASSERT_SVH
`define MULTI_STACK_SHARED_ARRAY_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mssa assertion failed");

// Next-cycle implication, checked outside reset.
`define MSSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mssa assertion failed");

`endif

// ===== rtl/mssa_pkg.sv =====
`timescale 1ns / 1ps
package mssa_pkg;

    localparam int DATA_W = 32;
    localparam int SEL_W  = 3;
    localparam int CFG_W  = 4;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADSEL = 2'd3
    } t_status;

    typedef struct packed {
        logic                     cmd;
        logic [SEL_W-1:0]         stack_sel;
        logic signed [DATA_W-1:0] push_value;
    } t_in_req;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] pop_value;
    } t_out_req;

endpackage

// ===== rtl/multi_stack_shared_array_unit.sv =====
`timescale 1ns / 1ps
// Several stacks sharing one slot memory, split into equal fixed regions.
// Input channel (i_in_valid / o_in_ready / i_in_data): one request pushes
// push_value onto stack stack_sel or pops its top entry.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per
// request, with status and the popped value (zero unless a pop succeeded).
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the stack
// count, sets the region size to TOTAL_SLOTS / count and empties all stacks.
// o_cfg_ready is always high; write only while no request is in flight.
// The result is valid in the cycle after the request is accepted, since the
// read of the single-port slot memory is registered.
// Throughput: one request per cycle while the receiver keeps i_out_ready high.
// When the receiver stalls, the result holds and o_in_ready stays low until
// it is taken.
// Reset (i_rst_n low, synchronous): all stacks empty, count 1, region size
// TOTAL_SLOTS, no result pending; slot contents are left as they are.
module multi_stack_shared_array_unit
    import mssa_pkg::*;
#(
    parameter int TOTAL_SLOTS = 32,
    parameter int MAX_STACKS  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_req            i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_req           o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int AW      = $clog2(TOTAL_SLOTS);
    localparam int RW      = $clog2(TOTAL_SLOTS + 1);
    localparam int SW      = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int PW      = RW + SEL_W;
    localparam int LIMIT   = (MAX_STACKS < TOTAL_SLOTS) ? MAX_STACKS : TOTAL_SLOTS;
    localparam int LIMIT_N = (LIMIT > 15) ? 15 : LIMIT;

    logic signed [DATA_W-1:0] r_mem [TOTAL_SLOTS];
    logic signed [DATA_W-1:0] r_rd_data;

    logic [RW-1:0]    r_fill [MAX_STACKS];
    logic [CFG_W-1:0] r_count;
    logic [RW-1:0]    r_region;
    logic             r_out_valid;
    t_status          r_status;
    logic             r_pop;

    logic [CFG_W-1:0] n_count;
    logic [RW-1:0]    n_region;

    logic             w_accept;
    logic             w_bad;
    logic [SW-1:0]    w_idx;
    logic [RW-1:0]    w_fill;
    logic [PW-1:0]    w_base;
    logic [PW-1:0]    w_sum;
    logic [AW-1:0]    w_addr;
    logic             w_wr;
    logic             w_rd;
    t_status          w_status;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_count = CFG_W'(1);
        end else if (i_cfg_data > CFG_W'(LIMIT_N)) begin
            n_count = CFG_W'(LIMIT_N);
        end else begin
            n_count = i_cfg_data;
        end
        unique case (n_count)
            4'd1:    n_region = RW'(TOTAL_SLOTS / 1);
            4'd2:    n_region = RW'(TOTAL_SLOTS / 2);
            4'd3:    n_region = RW'(TOTAL_SLOTS / 3);
            4'd4:    n_region = RW'(TOTAL_SLOTS / 4);
            4'd5:    n_region = RW'(TOTAL_SLOTS / 5);
            4'd6:    n_region = RW'(TOTAL_SLOTS / 6);
            4'd7:    n_region = RW'(TOTAL_SLOTS / 7);
            4'd8:    n_region = RW'(TOTAL_SLOTS / 8);
            4'd9:    n_region = RW'(TOTAL_SLOTS / 9);
            4'd10:   n_region = RW'(TOTAL_SLOTS / 10);
            4'd11:   n_region = RW'(TOTAL_SLOTS / 11);
            4'd12:   n_region = RW'(TOTAL_SLOTS / 12);
            4'd13:   n_region = RW'(TOTAL_SLOTS / 13);
            4'd14:   n_region = RW'(TOTAL_SLOTS / 14);
            4'd15:   n_region = RW'(TOTAL_SLOTS / 15);
            default: n_region = RW'(TOTAL_SLOTS);
        endcase
    end

    always_comb begin
        w_bad  = {1'b0, i_in_data.stack_sel} >= r_count;
        w_idx  = SW'(i_in_data.stack_sel);
        w_fill = r_fill[w_idx];
        w_base = PW'(i_in_data.stack_sel) * PW'(r_region);
        if (i_in_data.cmd == CMD_PUSH) begin
            w_sum = w_base + PW'(w_fill);
        end else begin
            w_sum = w_base + PW'(w_fill) - PW'(1);
        end
        w_addr = w_sum[AW-1:0];
        w_wr   = 1'b0;
        w_rd   = 1'b0;
        priority if (w_bad) begin
            w_status = ST_BADSEL;
        end else if (i_in_data.cmd == CMD_PUSH) begin
            if (w_fill >= r_region) begin
                w_status = ST_FULL;
            end else begin
                w_status = ST_OK;
                w_wr     = w_accept;
            end
        end else begin
            if (w_fill == '0) begin
                w_status = ST_EMPTY;
            end else begin
                w_status = ST_OK;
                w_rd     = w_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_addr] <= i_in_data.push_value;
        end
        if (w_rd) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= CFG_W'(1);
            r_region    <= RW'(TOTAL_SLOTS);
            for (int i = 0; i < MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_count  <= n_count;
                r_region <= n_region;
                for (int i = 0; i < MAX_STACKS; i++) begin
                    r_fill[i] <= '0;
                end
            end else if (w_wr) begin
                r_fill[w_idx] <= w_fill + RW'(1);
            end else if (w_rd) begin
                r_fill[w_idx] <= w_fill - RW'(1);
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_pop    <= w_rd;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_data.status    = r_status;
    assign o_out_data.pop_value = r_pop ? r_rd_data : '0;

endmodule

// ===== rtl/mssa_checker.sv =====
`timescale 1ns / 1ps
`include "multi_stack_shared_array_unit_assert.svh"
module mssa_checker
    import mssa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input t_in_req            i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input t_out_req           o_out_data
);

    logic w_acc;
    logic w_stall;
    logic w_fail;
    logic w_push;
    logic w_pop;
    logic w_push_res;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_stall    = o_out_valid && !i_out_ready;
    assign w_fail     = o_out_valid && (o_out_data.status != ST_OK);
    assign w_push     = w_acc && (i_in_data.cmd == CMD_PUSH);
    assign w_pop      = w_acc && (i_in_data.cmd == CMD_POP);
    assign w_push_res = (o_out_data.status != ST_EMPTY) && (o_out_data.pop_value == '0);

    `MSSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stall, o_out_valid && $stable(o_out_data))
    `MSSA_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, w_acc, o_out_valid)
    `MSSA_ASSERT_NOW(a_pop_zero, i_clk, i_rst_n, w_fail, o_out_data.pop_value == '0)
    `MSSA_ASSERT_NXT(a_push_status, i_clk, i_rst_n, w_push, w_push_res)
    `MSSA_ASSERT_NXT(a_pop_status, i_clk, i_rst_n, w_pop, o_out_data.status != ST_FULL)

endmodule

bind multi_stack_shared_array_unit mssa_checker u_mssa_checker (.*);
